// ----- rtl/rational_arithmetic_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rational arithmetic unit
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// implication checked every cycle outside reset
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication outside reset
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Widths, opcodes, status codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int unsigned FieldBitsDef = 32;
	localparam int unsigned InBits       = 32;
	localparam int unsigned MagBits      = 64;
	localparam int unsigned MulBits      = 32;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_MUL0,
		CMD_MUL1,
		CMD_MUL2,
		CMD_SUM,
		CMD_GCD_INIT,
		CMD_DIV_INIT,
		CMD_STEP,
		CMD_DIV_NUM_DONE,
		CMD_DIV_DEN_DONE,
		CMD_GCD_SWAP,
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		logic den_zero;
		logic num_zero;
		logic rem_zero;
		logic step_last;
	} dp_status_t;

endpackage

// ----- rtl/rau_datapath.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic datapath
// Operand decode, shared 32x32 multiplier, sum, serial restoring divider for
// gcd remainders and exact quotients, and result formatting.
// ----------------------------------------------------------------------------
module rau_datapath #(
	parameter int unsigned FIELD_BITS = rau_pkg::FieldBitsDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rau_pkg::cmd_t                  cmd,
	input  logic [1:0]                     op,
	input  logic [rau_pkg::InBits-1:0]     a_num,
	input  logic [rau_pkg::InBits-1:0]     a_den,
	input  logic [rau_pkg::InBits-1:0]     b_num,
	input  logic [rau_pkg::InBits-1:0]     b_den,
	output rau_pkg::dp_status_t            stat,
	output logic [31:0]                    res_num,
	output logic [30:0]                    res_den,
	output logic [1:0]                     status
);

	localparam int unsigned M = rau_pkg::MagBits;
	localparam int unsigned W = rau_pkg::MulBits;
	localparam logic [M-1:0] Lim = M'(1) << (FIELD_BITS - 1);

	logic [W-1:0] ma_q, mb_q, mc_q, md_q;
	logic         sa_q, sb_q, sc_q, sd_q;
	logic [1:0]   op_q;
	logic [M-1:0] p0_q, p1_q;
	logic         s0_q, s1_q;
	logic [M-1:0] num_q, den_q;
	logic         nneg_q, dneg_q;
	logic [M-1:0] gy_q;
	logic [M-1:0] dividend_q, divisor_q, rem_q, quo_q;
	logic [5:0]   cnt_q;
	logic [M-1:0] mul_p;
	logic [M:0]   trial;
	logic [M-1:0] rem_sh;
	logic         neg_res;
	logic         ovf;
	logic [M-1:0] sum_mag;
	logic         sum_neg;
	logic         yneg;

	function automatic logic [W-1:0] mag32(input logic [W-1:0] v);
		mag32 = v[W-1] ? (~v + W'(1)) : v;
	endfunction

	assign mul_p = M'(ma_q) * M'(mb_q);

	assign rem_sh = {rem_q[M-2:0], dividend_q[M-1]};
	assign trial  = {1'b0, rem_sh} - {1'b0, divisor_q};

	always_comb begin
		yneg = (op_q == rau_pkg::OP_SUB) ? ~s1_q : s1_q;
		if (p1_q == '0)
			yneg = 1'b0;
		if (s0_q == yneg) begin
			sum_mag = p0_q + p1_q;
			sum_neg = s0_q;
		end else if (p0_q >= p1_q) begin
			sum_mag = p0_q - p1_q;
			sum_neg = s0_q;
		end else begin
			sum_mag = p1_q - p0_q;
			sum_neg = yneg;
		end
		if (sum_mag == '0)
			sum_neg = 1'b0;
	end

	assign neg_res = (num_q != '0) && (nneg_q != dneg_q);
	assign ovf = (den_q > Lim - M'(1)) || (neg_res ? (num_q > Lim) : (num_q > Lim - M'(1)));

	assign stat.den_zero  = (den_q == '0);
	assign stat.num_zero  = (num_q == '0);
	assign stat.rem_zero  = (rem_q == '0);
	assign stat.step_last = (cnt_q == 6'd0);

	always_ff @(posedge clk) begin
		unique case (cmd)
			rau_pkg::CMD_LOAD: begin
				op_q <= op;
				sa_q <= a_num[W-1]; sb_q <= a_den[W-1];
				sc_q <= b_num[W-1]; sd_q <= b_den[W-1];
				ma_q <= mag32(a_num); mb_q <= mag32(a_den);
				mc_q <= mag32(b_num); md_q <= mag32(b_den);
			end
			rau_pkg::CMD_MUL0: begin
				// set up a_num*b_den (or a_num*b_num for multiply) in the mag slots
				if (op_q == rau_pkg::OP_MUL) begin
					ma_q <= ma_q; mb_q <= mc_q; mc_q <= mb_q;
					sb_q <= sc_q; sc_q <= sb_q;
				end else begin
					mb_q <= md_q; md_q <= mb_q;
					sb_q <= sd_q; sd_q <= sb_q;
				end
			end
			rau_pkg::CMD_MUL1: begin
				p0_q <= mul_p;
				s0_q <= (mul_p != '0) && (sa_q != sb_q);
				// next: c * d  (b_num*a_den for add/sub, a_den*b_den for mul,
				// a_den*b_num for div); keep b_den (b_num for mul) in the c slot
				ma_q <= mc_q; mb_q <= md_q; mc_q <= mb_q;
				sa_q <= sc_q; sb_q <= sd_q; sc_q <= sb_q;
			end
			rau_pkg::CMD_MUL2: begin
				p1_q <= mul_p;
				s1_q <= (mul_p != '0) && (sa_q != sb_q);
				// den for add/sub: a_den*b_den
				ma_q <= mb_q; mb_q <= mc_q;
				sa_q <= sb_q; sb_q <= sc_q;
			end
			rau_pkg::CMD_SUM: begin
				if (op_q == rau_pkg::OP_ADD || op_q == rau_pkg::OP_SUB) begin
					num_q  <= sum_mag;
					nneg_q <= sum_neg;
					den_q  <= mul_p;
					dneg_q <= (mul_p != '0) && (sa_q != sb_q);
				end else begin
					num_q  <= p0_q;
					nneg_q <= s0_q;
					den_q  <= p1_q;
					dneg_q <= s1_q;
				end
			end
			rau_pkg::CMD_GCD_INIT: begin
				gy_q <= den_q;
				dividend_q <= num_q;
				divisor_q  <= den_q;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= 6'(M - 1);
			end
			rau_pkg::CMD_GCD_SWAP: begin
				gy_q <= rem_q;
				dividend_q <= gy_q;
				divisor_q  <= rem_q;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= 6'(M - 1);
			end
			rau_pkg::CMD_STEP: begin
				dividend_q <= {dividend_q[M-2:0], 1'b0};
				if (!trial[M]) begin
					rem_q <= trial[M-1:0];
					quo_q <= {quo_q[M-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[M-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
			end
			rau_pkg::CMD_DIV_INIT: begin
				// gy_q holds the gcd; divide numerator first
				dividend_q <= num_q;
				divisor_q  <= gy_q;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= 6'(M - 1);
			end
			rau_pkg::CMD_DIV_NUM_DONE: begin
				num_q <= quo_q;
				dividend_q <= den_q;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= 6'(M - 1);
			end
			rau_pkg::CMD_DIV_DEN_DONE: begin
				den_q <= quo_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_num <= '0;
			res_den <= '0;
			status  <= rau_pkg::ST_OK;
		end else if (cmd == rau_pkg::CMD_FINISH) begin
			res_num <= '0;
			res_den <= '0;
			if (den_q == '0) begin
				status <= rau_pkg::ST_DIV0;
			end else if (ovf) begin
				status <= rau_pkg::ST_OVF;
			end else begin
				status  <= rau_pkg::ST_OK;
				res_num <= neg_res ? (32'd0 - num_q[31:0]) : num_q[31:0];
				res_den <= den_q[30:0];
			end
		end
	end

endmodule

// ----- rtl/rau_ctrl.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic controller
// Sequences products, gcd iterations, exact divisions and result hand-off.
// ----------------------------------------------------------------------------
module rau_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_fire,
	input  logic                  out_fire,
	input  rau_pkg::dp_status_t   stat,
	output rau_pkg::cmd_t         cmd,
	output logic                  busy,
	output logic                  out_valid
);

	typedef enum logic [3:0] {
		S_IDLE, S_M0, S_M1, S_M2, S_SUM, S_CHK, S_GSTEP, S_GNEXT,
		S_DNUM, S_NDONE, S_DDEN, S_DDONE, S_FIN, S_OUT
	} state_t;

	state_t state_q;

	assign busy      = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = rau_pkg::CMD_NONE;
		unique case (state_q)
			S_IDLE:  cmd = in_fire ? rau_pkg::CMD_LOAD : rau_pkg::CMD_NONE;
			S_M0:    cmd = rau_pkg::CMD_MUL0;
			S_M1:    cmd = rau_pkg::CMD_MUL1;
			S_M2:    cmd = rau_pkg::CMD_MUL2;
			S_SUM:   cmd = rau_pkg::CMD_SUM;
			S_CHK:   cmd = (stat.den_zero || stat.num_zero) ? rau_pkg::CMD_FINISH
				: rau_pkg::CMD_GCD_INIT;
			S_GSTEP: cmd = rau_pkg::CMD_STEP;
			S_GNEXT: cmd = stat.rem_zero ? rau_pkg::CMD_DIV_INIT : rau_pkg::CMD_GCD_SWAP;
			S_DNUM:  cmd = rau_pkg::CMD_STEP;
			S_NDONE: cmd = rau_pkg::CMD_DIV_NUM_DONE;
			S_DDEN:  cmd = rau_pkg::CMD_STEP;
			S_DDONE: cmd = rau_pkg::CMD_DIV_DEN_DONE;
			S_FIN:   cmd = rau_pkg::CMD_FINISH;
			S_OUT:   cmd = rau_pkg::CMD_NONE;
			default: cmd = rau_pkg::CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (in_fire) state_q <= S_M0;
				S_M0:    state_q <= S_M1;
				S_M1:    state_q <= S_M2;
				S_M2:    state_q <= S_SUM;
				S_SUM:   state_q <= S_CHK;
				S_CHK:   state_q <= (stat.den_zero || stat.num_zero) ? S_OUT : S_GSTEP;
				S_GSTEP: if (stat.step_last) state_q <= S_GNEXT;
				S_GNEXT: state_q <= stat.rem_zero ? S_DNUM : S_GSTEP;
				S_DNUM:  if (stat.step_last) state_q <= S_NDONE;
				S_NDONE: state_q <= S_DDEN;
				S_DDEN:  if (stat.step_last) state_q <= S_DDONE;
				S_DDONE: state_q <= S_FIN;
				S_FIN:   state_q <= S_OUT;
				S_OUT:   if (out_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
// For a zero numerator or zero denominator the products, sum and check lead
// straight to the result; otherwise Euclidean remainder steps find the gcd and
// two exact divisions by it follow. One transaction is handled at a time; the
// serial 64-bit restoring divider produces one quotient bit per cycle, and
// s_tready returns in the cycle after the result is taken.
// Reset: arst_n clears the controller and the output register asynchronously.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions and reduces by gcd.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
	parameter int unsigned FIELD_BITS = rau_pkg::FieldBitsDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,  // op[1:0], a_num, a_den, b_num, b_den, zero pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata   // res_num[31:0], res_den[62:32], status[64:63], pad
);

	rau_pkg::cmd_t       cmd;
	rau_pkg::dp_status_t stat;
	logic                busy;
	logic [31:0]         res_num;
	logic [30:0]         res_den;
	logic [1:0]          status;
	logic                in_fire;
	logic                out_fire;

	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;
	assign m_tdata  = {7'd0, status, res_den, res_num};

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.out_fire  (out_fire),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.out_valid (m_tvalid)
	);

	rau_datapath #(.FIELD_BITS(FIELD_BITS)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.op      (s_tdata[1:0]),
		.a_num   (s_tdata[33:2]),
		.a_den   (s_tdata[65:34]),
		.b_num   (s_tdata[97:66]),
		.b_den   (s_tdata[129:98]),
		.stat    (stat),
		.res_num (res_num),
		.res_den (res_den),
		.status  (status)
	);

endmodule

// ----- rtl/rau_checker.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level checks on handshake and result coding.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_macros.svh"

module rau_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [71:0]  m_tdata
);

	logic [1:0] res_status;
	logic       code_ok;

	assign res_status = m_tdata[64:63];
	assign code_ok    = (res_status == rau_pkg::ST_OK) || (res_status == rau_pkg::ST_DIV0)
		|| (res_status == rau_pkg::ST_OVF);

	`RAU_ASSERT_IMP(a_status_code, clk, arst_n, m_tvalid, code_ok, "bad status")
	`RAU_ASSERT_IMP(a_err_zero, clk, arst_n, m_tvalid && res_status != rau_pkg::ST_OK, m_tdata[62:0] == 63'd0, "error result not zero")
	`RAU_ASSERT_IMP(a_no_overlap, clk, arst_n, m_tvalid, !s_tready, "input taken while result pending")
	`RAU_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
